@@ rtl/core/grmd_pkg.sv @@
// Shared constants, codes and control types of the gated running mean/deviation core.
package grmd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int SUM_W     = 32;
  localparam int DEV_W     = 48;
  localparam int TIME_W    = 32;
  localparam int SQ_W      = 64;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 2;

  // gate arithmetic: 10 * mean needs four extra bits over the sample width
  localparam int GATE_W    = SAMPLE_W + 4;
  localparam int GATE_MIN  = 5;

  localparam int MEAN_POS_MAX = 2 ** (SAMPLE_W - 1) - 1;

  // serial units
  localparam int MUL_W      = 32;
  localparam int MUL_STEPS  = MUL_W / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
  localparam int DIV_CNT_W  = $clog2(DEV_W + 1);

  typedef enum logic [STAT_W-1:0] {
    STAT_ACCEPT = 2'd0,
    STAT_GATED  = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SUM     = 2'd0,
    CFG_START_DEV_SUM = 2'd1,
    CFG_START_COUNT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_DEV_START,
    S_DEV_WAIT,
    S_MSD_START,
    S_MSD_WAIT,
    S_SQ_START,
    S_SQ_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/core/grmd_div.sv @@
// Bit-serial restoring divider: dividend shifts out one bit per cycle, quotient shifts in.
module grmd_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  grmd_pkg::div_req_t              req,
  input  logic [grmd_pkg::DEV_W-1:0]      dividend,
  input  logic [grmd_pkg::COUNT_W-1:0]    divisor,
  output grmd_pkg::unit_stat_t            stat,
  output logic [grmd_pkg::DEV_W-1:0]      quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [grmd_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [grmd_pkg::DEV_W-1:0]        q_r;
  logic [grmd_pkg::COUNT_W-1:0]      rem_r;
  logic [grmd_pkg::COUNT_W-1:0]      div_r;
  logic [grmd_pkg::COUNT_W:0]        rem_sh;
  logic [grmd_pkg::COUNT_W:0]        rem_diff;
  logic                              ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[grmd_pkg::DEV_W-1]};
    rem_diff = rem_sh - {1'b0, div_r};
    ge       = (rem_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == grmd_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[grmd_pkg::DEV_W-2:0], ge};
      rem_r <= ge ? rem_diff[grmd_pkg::COUNT_W-1:0] : rem_sh[grmd_pkg::COUNT_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

@@ rtl/core/grmd_sqr.sv @@
// Radix-4 serial squarer: two multiplier bits per cycle, low product bits shift out.
module grmd_sqr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grmd_pkg::MUL_W-1:0]    operand,
  output grmd_pkg::unit_stat_t          stat,
  output logic [grmd_pkg::SQ_W-1:0]     product
);

  logic                              busy_r;
  logic                              done_r;
  logic [grmd_pkg::MUL_CNT_W-1:0]    cnt_r;
  logic [grmd_pkg::MUL_W-1:0]        a_r;
  logic [grmd_pkg::MUL_W+1:0]        a3_r;
  logic [grmd_pkg::MUL_W-1:0]        b_r;
  logic [grmd_pkg::MUL_W-1:0]        hi_r;
  logic [grmd_pkg::MUL_W+1:0]        addend;
  logic [grmd_pkg::MUL_W+1:0]        sum;

  always_comb begin
    case (b_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a_r};
      2'd2:    addend = {1'b0, a_r, 1'b0};
      default: addend = a3_r;
    endcase
    sum = {2'b00, hi_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= grmd_pkg::MUL_CNT_W'(grmd_pkg::MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == grmd_pkg::MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= operand;
      a3_r <= {2'b00, operand} + {1'b0, operand, 1'b0};
      b_r  <= operand;
      hi_r <= '0;
    end else if (busy_r) begin
      hi_r <= sum[grmd_pkg::MUL_W+1:2];
      b_r  <= {sum[1:0], b_r[grmd_pkg::MUL_W-1:2]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, b_r};

endmodule

@@ rtl/core/gated_running_mean_deviation_core.sv @@
// Top level: outlier gate, running sum/mean/deviation state and the sequencer over the serial units.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  in      | in_sample, in_timestamp_us              | in_valid / in_ready
//  out     | out_status .. out_period_us             | out_valid / out_ready
//  cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait, no read-back
//
// A gated or count-full word goes from idle straight to the done state, without the serial units.
// An accepted word runs the serial units in turn: the bit-serial divider runs 32 steps
// for the mean and 48 for the mean squared deviation, the radix-4 squarer
// 16 steps for the deviation and 16 for the square, skipped above a 32-bit mean squared deviation.
// in_ready is high only in idle; a finished result waits in the output register
// while the next word is taken. Reset clears the sequencer, the running state and out_valid only.
module gated_running_mean_deviation_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [grmd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [grmd_pkg::TIME_W-1:0]         in_timestamp_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [grmd_pkg::STAT_W-1:0]         out_status,
  output logic [grmd_pkg::COUNT_W-1:0]        out_sample_count,
  output logic signed [grmd_pkg::SAMPLE_W-1:0] out_mean_value,
  output logic [grmd_pkg::DEV_W-1:0]          out_mean_sq_dev,
  output logic [grmd_pkg::SQ_W-1:0]           out_mean_sq_dev_squared,
  output logic [grmd_pkg::TIME_W-1:0]         out_period_us,
  input  logic                                cfg_we,
  input  logic [grmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grmd_pkg::CFG_W-1:0]          cfg_wdata
);

  grmd_pkg::state_t                   state_r, state_nxt;

  // running state
  logic [grmd_pkg::COUNT_W-1:0]       count_r;
  logic [grmd_pkg::SUM_W-1:0]         run_sum_r;
  logic [grmd_pkg::DEV_W-1:0]         dev_sum_r;
  logic [grmd_pkg::SAMPLE_W-1:0]      mean_r;
  logic [grmd_pkg::TIME_W-1:0]        last_time_r;
  logic [grmd_pkg::TIME_W-1:0]        period_r;
  logic [grmd_pkg::DEV_W-1:0]         msd_r;
  logic [grmd_pkg::SQ_W-1:0]          sq_r;

  // word in flight
  logic [grmd_pkg::SAMPLE_W-1:0]      sample_r;
  grmd_pkg::status_t                  status_r;

  // output register
  logic                               out_valid_r;
  grmd_pkg::status_t                  out_status_r;
  logic [grmd_pkg::COUNT_W-1:0]       out_count_r;
  logic [grmd_pkg::SAMPLE_W-1:0]      out_mean_r;
  logic [grmd_pkg::DEV_W-1:0]         out_msd_r;
  logic [grmd_pkg::SQ_W-1:0]          out_sq_r;
  logic [grmd_pkg::TIME_W-1:0]        out_period_r;

  // control
  logic                               accept;
  logic                               out_load;
  grmd_pkg::div_req_t                 div_req;
  grmd_pkg::unit_stat_t               div_stat;
  logic [grmd_pkg::DEV_W-1:0]         div_dividend;
  logic [grmd_pkg::DEV_W-1:0]         div_quot;
  logic                               sqr_start;
  logic [grmd_pkg::MUL_W-1:0]         sqr_operand;
  grmd_pkg::unit_stat_t               sqr_stat;
  logic [grmd_pkg::SQ_W-1:0]          sqr_prod;

  // gate and datapath
  logic signed [grmd_pkg::GATE_W-1:0] s_ext;
  logic signed [grmd_pkg::GATE_W-1:0] m_ext;
  logic signed [grmd_pkg::GATE_W-1:0] m10;
  logic signed [grmd_pkg::GATE_W-1:0] s5;
  logic                               gate_ok;
  logic                               cnt_full;
  logic [grmd_pkg::SUM_W:0]           sum_wide;
  logic [grmd_pkg::SUM_W-1:0]         sum_sat;
  logic [grmd_pkg::SUM_W-1:0]         sum_mag;
  logic [grmd_pkg::SUM_W-1:0]         q_mean;
  logic [grmd_pkg::SAMPLE_W-1:0]      mean_sat;
  logic [grmd_pkg::SAMPLE_W:0]        diff;
  logic [grmd_pkg::SAMPLE_W:0]        diff_mag;
  logic [grmd_pkg::DEV_W:0]           dev_wide;
  logic [grmd_pkg::DEV_W-1:0]         dev_sat;
  logic                               msd_big;

  always_comb begin
    s_ext    = grmd_pkg::GATE_W'(in_sample);
    m_ext    = grmd_pkg::GATE_W'($signed(mean_r));
    m10      = (m_ext <<< 3) + (m_ext <<< 1);
    s5       = (s_ext <<< 2) + s_ext;
    cnt_full = &count_r;
    gate_ok  = ((s_ext < m10) && (s5 > m_ext)) || (in_sample == '0) ||
               (count_r < grmd_pkg::COUNT_W'(grmd_pkg::GATE_MIN));

    // saturating running sum
    sum_wide = {run_sum_r[grmd_pkg::SUM_W-1], run_sum_r} +
               (grmd_pkg::SUM_W+1)'(in_sample);
    if (sum_wide[grmd_pkg::SUM_W] != sum_wide[grmd_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[grmd_pkg::SUM_W] ? {1'b1, {(grmd_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(grmd_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[grmd_pkg::SUM_W-1:0];
    end

    sum_mag = run_sum_r[grmd_pkg::SUM_W-1] ? (~run_sum_r + 1'b1) : run_sum_r;

    // quotient magnitude back to a signed, range-limited mean
    q_mean = div_quot[grmd_pkg::SUM_W-1:0];
    if (!run_sum_r[grmd_pkg::SUM_W-1]) begin
      if (q_mean > grmd_pkg::SUM_W'(grmd_pkg::MEAN_POS_MAX)) begin
        mean_sat = {1'b0, {(grmd_pkg::SAMPLE_W-1){1'b1}}};
      end else begin
        mean_sat = q_mean[grmd_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (q_mean > grmd_pkg::SUM_W'(grmd_pkg::MEAN_POS_MAX + 1)) begin
        mean_sat = {1'b1, {(grmd_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
        mean_sat = ~q_mean[grmd_pkg::SAMPLE_W-1:0] + 1'b1;
      end
    end

    diff     = {sample_r[grmd_pkg::SAMPLE_W-1], sample_r} -
               {mean_r[grmd_pkg::SAMPLE_W-1], mean_r};
    diff_mag = diff[grmd_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;

    dev_wide = {1'b0, dev_sum_r} +
               {{(grmd_pkg::DEV_W+1-grmd_pkg::MUL_W){1'b0}}, sqr_prod[grmd_pkg::MUL_W-1:0]};
    dev_sat  = dev_wide[grmd_pkg::DEV_W] ? '1 : dev_wide[grmd_pkg::DEV_W-1:0];

    msd_big  = |msd_r[grmd_pkg::DEV_W-1:grmd_pkg::MUL_W];

    if (state_r == grmd_pkg::S_MSD_START) begin
      div_dividend = dev_sum_r;
    end else begin
      div_dividend = {sum_mag, {(grmd_pkg::DEV_W-grmd_pkg::SUM_W){1'b0}}};
    end

    if (state_r == grmd_pkg::S_SQ_START) begin
      sqr_operand = msd_r[grmd_pkg::MUL_W-1:0];
    end else begin
      sqr_operand = {{(grmd_pkg::MUL_W-grmd_pkg::SAMPLE_W){1'b0}},
                     diff_mag[grmd_pkg::SAMPLE_W-1:0]};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    sqr_start     = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = (state_r == grmd_pkg::S_MSD_START) ?
                    grmd_pkg::DIV_CNT_W'(grmd_pkg::DEV_W) :
                    grmd_pkg::DIV_CNT_W'(grmd_pkg::SUM_W);
    unique case (state_r)
      grmd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = (!cnt_full && gate_ok) ? grmd_pkg::S_MEAN_START : grmd_pkg::S_DONE;
        end
      end
      grmd_pkg::S_MEAN_START: begin
        div_req.start = 1'b1;
        state_nxt     = grmd_pkg::S_MEAN_WAIT;
      end
      grmd_pkg::S_MEAN_WAIT: begin
        if (div_stat.done) state_nxt = grmd_pkg::S_DEV_START;
      end
      grmd_pkg::S_DEV_START: begin
        sqr_start = 1'b1;
        state_nxt = grmd_pkg::S_DEV_WAIT;
      end
      grmd_pkg::S_DEV_WAIT: begin
        if (sqr_stat.done) state_nxt = grmd_pkg::S_MSD_START;
      end
      grmd_pkg::S_MSD_START: begin
        div_req.start = 1'b1;
        state_nxt     = grmd_pkg::S_MSD_WAIT;
      end
      grmd_pkg::S_MSD_WAIT: begin
        if (div_stat.done) state_nxt = grmd_pkg::S_SQ_START;
      end
      grmd_pkg::S_SQ_START: begin
        // above 32 bits the square saturates, no need to run the squarer
        if (msd_big) begin
          state_nxt = grmd_pkg::S_DONE;
        end else begin
          sqr_start = 1'b1;
          state_nxt = grmd_pkg::S_SQ_WAIT;
        end
      end
      grmd_pkg::S_SQ_WAIT: begin
        if (sqr_stat.done) state_nxt = grmd_pkg::S_DONE;
      end
      grmd_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = grmd_pkg::S_IDLE;
        end
      end
      default: state_nxt = grmd_pkg::S_IDLE;
    endcase
  end

  assign accept = in_valid && (state_r == grmd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grmd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      run_sum_r   <= '0;
      dev_sum_r   <= '0;
      mean_r      <= '0;
      last_time_r <= '0;
      period_r    <= '0;
      msd_r       <= '0;
      sq_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (grmd_pkg::cfg_idx_t'(cfg_index))
          grmd_pkg::CFG_START_SUM:     run_sum_r <= cfg_wdata[grmd_pkg::SUM_W-1:0];
          grmd_pkg::CFG_START_DEV_SUM: dev_sum_r <= cfg_wdata[grmd_pkg::DEV_W-1:0];
          grmd_pkg::CFG_START_COUNT:   count_r   <= cfg_wdata[grmd_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        grmd_pkg::S_IDLE: begin
          if (in_valid && !cnt_full && gate_ok) begin
            count_r     <= count_r + 1'b1;
            last_time_r <= in_timestamp_us;
            period_r    <= in_timestamp_us - last_time_r;
            run_sum_r   <= sum_sat;
          end
        end
        grmd_pkg::S_MEAN_WAIT: begin
          if (div_stat.done) mean_r <= mean_sat;
        end
        grmd_pkg::S_DEV_WAIT: begin
          if (sqr_stat.done) dev_sum_r <= dev_sat;
        end
        grmd_pkg::S_MSD_WAIT: begin
          if (div_stat.done) msd_r <= div_quot;
        end
        grmd_pkg::S_SQ_START: begin
          if (msd_big) sq_r <= '1;
        end
        grmd_pkg::S_SQ_WAIT: begin
          if (sqr_stat.done) sq_r <= sqr_prod;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      if (cnt_full) begin
        status_r <= grmd_pkg::STAT_FULL;
      end else if (!gate_ok) begin
        status_r <= grmd_pkg::STAT_GATED;
      end else begin
        status_r <= grmd_pkg::STAT_ACCEPT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_mean_r   <= mean_r;
      out_msd_r    <= msd_r;
      out_sq_r     <= sq_r;
      out_period_r <= period_r;
    end
  end

  grmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  grmd_sqr u_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqr_start),
    .operand (sqr_operand),
    .stat    (sqr_stat),
    .product (sqr_prod)
  );

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_sample_count        = out_count_r;
  assign out_mean_value          = $signed(out_mean_r);
  assign out_mean_sq_dev         = out_msd_r;
  assign out_mean_sq_dev_squared = out_sq_r;
  assign out_period_us           = out_period_r;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy && !sqr_stat.busy)
    else $error("divider started while a serial unit is busy");

  a_sqr_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sqr_start |-> !sqr_stat.busy && !div_stat.busy)
    else $error("squarer started while a serial unit is busy");

  a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy && !sqr_stat.busy)
    else $error("input ready while a serial unit is busy");

  a_mean_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grmd_pkg::S_DEV_START) |->
      (mean_r == '0) || (mean_r[grmd_pkg::SAMPLE_W-1] == run_sum_r[grmd_pkg::SUM_W-1]))
    else $error("mean sign differs from running sum sign");

  a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status_r == grmd_pkg::STAT_ACCEPT) |-> (count_r != '0))
    else $error("accepted word reported with zero count");
`endif

endmodule
